// File: rtl/owbm_pkg.sv
// owbm_pkg: shared types and constants of the one-wire bus master
`default_nettype none
package owbm_pkg;

  localparam int TIMER_WIDTH = 12;
  localparam int REG_WIDTH   = 12;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PRES_END      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BYTE_GAP      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_READ_WAIT     = 3'd7;

  // register values after reset
  localparam logic [REG_WIDTH-1:0] RST_RESET_LOW   = 12'd4000;
  localparam logic [REG_WIDTH-1:0] RST_PRES_SAMPLE = 12'd240;
  localparam logic [REG_WIDTH-1:0] RST_PRES_END    = 12'd3920;
  localparam logic [REG_WIDTH-1:0] RST_WRITE_LOW   = 12'd40;
  localparam logic [REG_WIDTH-1:0] RST_WRITE_SLOT  = 12'd680;
  localparam logic [REG_WIDTH-1:0] RST_BYTE_GAP    = 12'd800;
  localparam logic [REG_WIDTH-1:0] RST_READ_LOW    = 12'd16;
  localparam logic [REG_WIDTH-1:0] RST_READ_WAIT   = 12'd120;

  // command codes
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // bus sequencer phases
  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_RST_LOW   = 9'b000000010,
    PH_RST_WAIT1 = 9'b000000100,
    PH_RST_WAIT2 = 9'b000001000,
    PH_WR_SLOT   = 9'b000010000,
    PH_WR_GAP    = 9'b000100000,
    PH_RD_LOW    = 9'b001000000,
    PH_RD_WAIT   = 9'b010000000,
    PH_RD_REC    = 9'b100000000
  } phase_t;

  // stream widths and result field positions
  localparam int S_DATA_W  = 16;
  localparam int S_USER_W  = 2;
  localparam int M_DATA_W  = 16;
  localparam int M_DROVE   = 0;
  localparam int M_BUSY    = 1;
  localparam int M_DONE    = 2;
  localparam int M_PRES    = 3;
  localparam int M_RXLO    = 4;
  localparam int M_RXHI    = 11;
  localparam int M_REJ     = 12;

  // phase length from a register: zero counts as one tick
  function automatic logic [TIMER_WIDTH:0] span(input logic [REG_WIDTH-1:0] v);
    logic [TIMER_WIDTH:0] r;
    r = (v == '0) ? (TIMER_WIDTH+1)'(1) : (TIMER_WIDTH+1)'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/one_wire_bus_master.sv
// one_wire_bus_master: tick-timed 1-wire reset, write byte and read byte sequencer
// a tick transaction is accepted into the input register, then its result is registered
// in the result register; the block takes one tick per cycle while the result side is not stalled
// the sequencer state advances once per tick as it moves into the result stage
// reset (rst, synchronous) empties both stages, returns the sequencer to idle
// and loads the default timing registers
`default_nettype none
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  // configuration write port
  input  wire                    cfg_we,
  input  wire [REG_IDX_W-1:0]    cfg_addr,
  input  wire [REG_WIDTH-1:0]    cfg_data,
  // tick input
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire [S_DATA_W-1:0]     s_tdata,  // data_byte[7:0], line_level[8], zero[15:9]
  input  wire [S_USER_W-1:0]     s_tuser,  // op[1:0]
  // tick result
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [M_DATA_W-1:0]    m_tdata   // drive_low[0], busy_res[1], done_res[2],
                                           // presence[3], received_byte[11:4],
                                           // rejected[12], zero[15:13]
);

  logic [REG_WIDTH-1:0] regs [NUM_REGS];

  // input stage
  logic       in_valid;
  op_t        in_op;
  logic [7:0] in_data;
  logic       in_line;

  // sequencer state
  phase_t               phase, phase_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]           bit_index, bit_index_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic                 first_sample_low, first_sample_low_next;
  logic                 presence_flag, presence_flag_next;
  logic [7:0]           rx_byte, rx_byte_next;

  logic drive, busy, done, rej;
  logic advance;

  // stage handshake
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_RESET_LOW]   <= RST_RESET_LOW;
      regs[REG_PRES_SAMPLE] <= RST_PRES_SAMPLE;
      regs[REG_PRES_END]    <= RST_PRES_END;
      regs[REG_WRITE_LOW]   <= RST_WRITE_LOW;
      regs[REG_WRITE_SLOT]  <= RST_WRITE_SLOT;
      regs[REG_BYTE_GAP]    <= RST_BYTE_GAP;
      regs[REG_READ_LOW]    <= RST_READ_LOW;
      regs[REG_READ_WAIT]   <= RST_READ_WAIT;
    end else if (cfg_we) begin
      regs[cfg_addr] <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_op   <= op_t'(s_tuser);
      in_data <= s_tdata[7:0];
      in_line <= s_tdata[8];
    end
  end

  // one tick of the sequencer
  always_comb begin
    phase_t               ph;
    logic [TIMER_WIDTH-1:0] tc;
    logic [2:0]           bi;
    logic [7:0]           sb;
    logic [TIMER_WIDTH:0] dur;
    logic                 last;

    ph  = phase;
    tc  = tick_count;
    bi  = bit_index;
    sb  = shift_byte;
    dur = span(regs[REG_READ_WAIT]);
    drive = 1'b0;
    busy  = 1'b0;
    done  = 1'b0;
    rej   = 1'b0;
    first_sample_low_next = first_sample_low;
    presence_flag_next    = presence_flag;
    rx_byte_next          = rx_byte;

    // command start or rejection
    if (phase != PH_IDLE) begin
      rej = (in_op != OP_NONE);
    end else if (in_op != OP_NONE) begin
      tc = '0;
      bi = '0;
      case (in_op)
        OP_RESET: ph = PH_RST_LOW;
        OP_WRITE: begin
          ph = PH_WR_SLOT;
          sb = in_data;
        end
        default: begin
          ph = PH_RD_LOW;
          sb = '0;
        end
      endcase
    end

    phase_next      = ph;
    tick_count_next = tc;
    bit_index_next  = bi;
    shift_byte_next = sb;

    if (ph != PH_IDLE) begin
      busy = 1'b1;
      // phase length and bus drive
      case (ph)
        PH_RST_LOW: begin
          dur   = span(regs[REG_RESET_LOW]);
          drive = 1'b1;
        end
        PH_RST_WAIT1: dur = span(regs[REG_PRES_SAMPLE]);
        PH_RST_WAIT2: dur = span(regs[REG_PRES_END]);
        PH_WR_SLOT: begin
          dur   = span(regs[REG_WRITE_SLOT]);
          drive = !sb[0] || ({1'b0, tc} < span(regs[REG_WRITE_LOW]));
        end
        PH_WR_GAP: dur = span(regs[REG_BYTE_GAP]);
        PH_RD_LOW: begin
          dur   = span(regs[REG_READ_LOW]);
          drive = 1'b1;
        end
        default: dur = span(regs[REG_READ_WAIT]);
      endcase

      last = (({1'b0, tc} + 1'b1) >= dur);
      if (!last) begin
        tick_count_next = tc + 1'b1;
      end else begin
        tick_count_next = '0;
        // phase transitions on the last tick
        case (ph)
          PH_RST_LOW: phase_next = PH_RST_WAIT1;
          PH_RST_WAIT1: begin
            first_sample_low_next = !in_line;
            phase_next            = PH_RST_WAIT2;
          end
          PH_RST_WAIT2: begin
            presence_flag_next = first_sample_low && in_line;
            phase_next         = PH_IDLE;
            bit_index_next     = '0;
            done               = 1'b1;
          end
          PH_WR_SLOT: begin
            shift_byte_next = {1'b0, sb[7:1]};
            if (bi == 3'd7) begin
              bit_index_next = '0;
              if (regs[REG_BYTE_GAP] == '0) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
              end else begin
                phase_next = PH_WR_GAP;
              end
            end else begin
              bit_index_next = bi + 1'b1;
            end
          end
          PH_WR_GAP: begin
            phase_next     = PH_IDLE;
            bit_index_next = '0;
            done           = 1'b1;
          end
          PH_RD_LOW: phase_next = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shift_byte_next = {in_line, sb[7:1]};
            phase_next      = PH_RD_REC;
          end
          default: begin
            if (bi == 3'd7) begin
              rx_byte_next   = sb;
              phase_next     = PH_IDLE;
              bit_index_next = '0;
              done           = 1'b1;
            end else begin
              bit_index_next = bi + 1'b1;
              phase_next     = PH_RD_LOW;
            end
          end
        endcase
      end
    end
  end

  // sequencer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      shift_byte       <= '0;
      first_sample_low <= 1'b0;
      presence_flag    <= 1'b0;
      rx_byte          <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      first_sample_low <= first_sample_low_next;
      presence_flag    <= presence_flag_next;
      rx_byte          <= rx_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
    if (advance) begin
      m_tdata <= {3'b000, rej, rx_byte_next, presence_flag_next, done, busy, drive};
    end
  end

endmodule
`default_nettype wire

// File: rtl/owbm_checker.sv
// owbm_checker: port-level checks of the one-wire bus master, bound to the top level
`default_nettype none
module owbm_checker
  import owbm_pkg::*;
(
  input wire                 clk,
  input wire                 rst,
  input wire                 m_tvalid,
  input wire                 m_tready,
  input wire [M_DATA_W-1:0]  m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // done, drive and rejection only happen during a command
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[M_DONE] || m_tdata[M_DROVE] || m_tdata[M_REJ]) |-> m_tdata[M_BUSY])
    else $error("done, drive or reject without busy");

  // the tick after a finished command is not a rejection
  a_no_rej_after_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[M_DONE] ##1 m_tvalid |-> !m_tdata[M_REJ])
    else $error("rejected right after done");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_DATA_W-1:M_REJ+1] == '0)
    else $error("nonzero padding in result");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: verif/one_wire_bus_master_test.sv
// one_wire_bus_master_test: self-checking stream testbench with a tick-level bus timing predictor
`timescale 1ns / 100ps
module one_wire_bus_master_test;
  import owbm_pkg::*;

  localparam int RANDOM_TICKS  = 1000;
  localparam int CFG_EVERY     = 150;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 20;

  // result word, fields from the lowest bit up: drive, busy, done, presence, byte, rejected
  typedef struct packed {
    logic [2:0] pad;
    logic       rej;
    logic [7:0] rx_byte;
    logic       pres;
    logic       done;
    logic       busy;
    logic       drive;
  } tick_word_t;

  // how the modeled bus answers while a command runs
  typedef enum int {LINE_RANDOM, LINE_HIGH, LINE_LOW, LINE_DEVICE} line_mode_t;

  // bus sequencer predictor and result checker
  class bus_tick_checker;
    logic [REG_WIDTH-1:0] timing [NUM_REGS];
    phase_t     phase;
    int         tick_cnt;
    logic [2:0] bit_idx;
    logic [7:0] shreg;
    logic       first_low;
    logic       pres;
    logic [7:0] rx;
    tick_word_t expected_ticks [$];
    int         errors;
    int         ticks;
    int         rejects;
    int         presence_hits;
    int         cmd_count [4];

    function new();
      errors = 0;
      ticks = 0;
      rejects = 0;
      presence_hits = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      timing[REG_RESET_LOW]   = RST_RESET_LOW;
      timing[REG_PRES_SAMPLE] = RST_PRES_SAMPLE;
      timing[REG_PRES_END]    = RST_PRES_END;
      timing[REG_WRITE_LOW]   = RST_WRITE_LOW;
      timing[REG_WRITE_SLOT]  = RST_WRITE_SLOT;
      timing[REG_BYTE_GAP]    = RST_BYTE_GAP;
      timing[REG_READ_LOW]    = RST_READ_LOW;
      timing[REG_READ_WAIT]   = RST_READ_WAIT;
      phase = PH_IDLE;
      tick_cnt = 0;
      bit_idx = '0;
      shreg = '0;
      first_low = 1'b0;
      pres = 1'b0;
      rx = '0;
    endfunction

    // phase length in ticks, a zero register lasts one tick
    function int ticks_of(logic [REG_IDX_W-1:0] idx);
      return (timing[idx] == '0) ? 1 : int'(timing[idx]);
    endfunction

    // note an accepted tick transaction and predict its result
    function void apply_tick(op_t op, logic [7:0] data, logic line);
      tick_word_t r;
      int dur;
      r = '0;
      dur = 1;
      ticks++;
      if (phase != PH_IDLE) begin
        r.rej = (op != OP_NONE);
        if (r.rej) rejects++;
      end else if (op != OP_NONE) begin
        cmd_count[op]++;
        tick_cnt = 0;
        bit_idx = '0;
        case (op)
          OP_RESET: phase = PH_RST_LOW;
          OP_WRITE: begin
            phase = PH_WR_SLOT;
            shreg = data;
          end
          default: begin
            phase = PH_RD_LOW;
            shreg = '0;
          end
        endcase
      end
      if (phase != PH_IDLE) begin
        r.busy = 1'b1;
        case (phase)
          PH_RST_LOW: begin
            dur = ticks_of(REG_RESET_LOW);
            r.drive = 1'b1;
          end
          PH_RST_WAIT1: dur = ticks_of(REG_PRES_SAMPLE);
          PH_RST_WAIT2: dur = ticks_of(REG_PRES_END);
          PH_WR_SLOT: begin
            dur = ticks_of(REG_WRITE_SLOT);
            r.drive = !shreg[0] || (tick_cnt < ticks_of(REG_WRITE_LOW));
          end
          PH_WR_GAP: dur = ticks_of(REG_BYTE_GAP);
          PH_RD_LOW: begin
            dur = ticks_of(REG_READ_LOW);
            r.drive = 1'b1;
          end
          default: dur = ticks_of(REG_READ_WAIT);
        endcase
        if (tick_cnt + 1 < dur) begin
          tick_cnt++;
        end else begin
          tick_cnt = 0;
          case (phase)
            PH_RST_LOW: phase = PH_RST_WAIT1;
            PH_RST_WAIT1: begin
              first_low = !line;
              phase = PH_RST_WAIT2;
            end
            PH_RST_WAIT2: begin
              pres = first_low && line;
              if (pres) presence_hits++;
              phase = PH_IDLE;
              bit_idx = '0;
              r.done = 1'b1;
            end
            PH_WR_SLOT: begin
              shreg = shreg >> 1;
              if (bit_idx == 3'd7) begin
                bit_idx = '0;
                // a zero byte gap ends the write on its last slot tick
                if (timing[REG_BYTE_GAP] == '0) begin
                  phase = PH_IDLE;
                  r.done = 1'b1;
                end else begin
                  phase = PH_WR_GAP;
                end
              end else begin
                bit_idx++;
              end
            end
            PH_WR_GAP: begin
              phase = PH_IDLE;
              bit_idx = '0;
              r.done = 1'b1;
            end
            PH_RD_LOW: phase = PH_RD_WAIT;
            PH_RD_WAIT: begin
              shreg = {line, shreg[7:1]};
              phase = PH_RD_REC;
            end
            default: begin
              if (bit_idx == 3'd7) begin
                rx = shreg;
                phase = PH_IDLE;
                bit_idx = '0;
                r.done = 1'b1;
              end else begin
                bit_idx++;
                phase = PH_RD_LOW;
              end
            end
          endcase
        end
      end
      r.pres = pres;
      r.rx_byte = rx;
      expected_ticks.push_back(r);
    endfunction

    function void report(string field, int want, int got);
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_tick(logic [M_DATA_W-1:0] word);
      tick_word_t got;
      tick_word_t want;
      got = word;
      if (expected_ticks.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      if (got.drive !== want.drive) report("drive_low", want.drive, got.drive);
      if (got.busy !== want.busy) report("busy", want.busy, got.busy);
      if (got.done !== want.done) report("done", want.done, got.done);
      if (got.pres !== want.pres) report("presence", want.pres, got.pres);
      if (got.rx_byte !== want.rx_byte) report("received_byte", want.rx_byte, got.rx_byte);
      if (got.rej !== want.rej) report("rejected", want.rej, got.rej);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_addr;
  logic [REG_WIDTH-1:0]  cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;  // data_byte[7:0], line_level[8], zero[15:9]
  logic [S_USER_W-1:0]   s_tuser;  // op[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;  // drive_low[0], busy[1], done[2], presence[3],
                                   // received_byte[11:4], rejected[12], zero[15:13]

  bus_tick_checker       sb;
  logic [REG_WIDTH-1:0]  timing_set [NUM_REGS];
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  bit                    hold_req;
  int                    stall_cycles;
  int                    timing_loads;

  one_wire_bus_master dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always #1 clk = ~clk;

  // result side: random backpressure, with a long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_tick(m_tdata);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("FAIL one_wire_bus_master");
      $finish;
    end
  end

  // bus level for the next tick, from the predicted phase
  function automatic logic line_for(line_mode_t mode);
    case (mode)
      LINE_HIGH:   return 1'b1;
      LINE_LOW:    return 1'b0;
      LINE_DEVICE: return (sb.phase != PH_RST_WAIT1);
      default:     return 1'($urandom_range(1));
    endcase
  endfunction

  // offer one tick transaction, called and left at a falling edge
  task automatic send_tick(input op_t op, input logic [7:0] data, input logic line);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, line, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.apply_tick(op, data, line);
    @(negedge clk);
  endtask

  // one command followed by filler ticks until the sequencer is idle again
  task automatic run_command(input op_t op, input logic [7:0] data, input line_mode_t mode,
                             input int noise_pct);
    op_t filler;
    send_tick(op, data, line_for(mode));
    while (sb.phase != PH_IDLE) begin
      filler = ($urandom_range(99) < noise_pct) ? op_t'($urandom_range(3, 1)) : OP_NONE;
      send_tick(filler, 8'($urandom_range(255)), line_for(mode));
    end
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // write all timing registers from timing_set while the block is idle
  task automatic load_timing();
    quiesce();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= REG_IDX_W'(i);
      cfg_data <= timing_set[i];
      @(negedge clk);
      sb.timing[i] = timing_set[i];
    end
    cfg_we <= 1'b0;
    timing_loads++;
  endtask

  // stimulus
  initial begin
    int n;
    int r;
    int next_cfg;
    int holds;
    int random_start;
    op_t op;
    line_mode_t mode;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_NONE;
    hold_req = 1'b0;
    stall_cycles = 0;
    timing_loads = 0;
    tx_idle_pct = 28;
    rx_idle_pct = 52;
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: idle ticks show no presence and an empty received byte
    run_command(OP_NONE, 8'h00, LINE_RANDOM, 0);
    run_command(OP_NONE, 8'h00, LINE_RANDOM, 0);

    // all registers zero: every phase one tick, no byte gap
    foreach (timing_set[i]) timing_set[i] = '0;
    load_timing();
    run_command(OP_RESET, 8'h00, LINE_DEVICE, 0);
    run_command(OP_RESET, 8'h00, LINE_LOW, 0);
    run_command(OP_RESET, 8'h00, LINE_HIGH, 50);
    run_command(OP_WRITE, 8'h00, LINE_RANDOM, 0);
    run_command(OP_WRITE, 8'hFF, LINE_RANDOM, 50);
    run_command(OP_WRITE, 8'hA5, LINE_RANDOM, 0);
    run_command(OP_READ, 8'h00, LINE_LOW, 0);
    run_command(OP_READ, 8'hFF, LINE_RANDOM, 30);
    run_command(OP_READ, 8'h00, LINE_HIGH, 0);

    // write low time longer than the slot, so every slot stays low
    timing_set = '{12'd1, 12'd2, 12'd2, 12'd7, 12'd3, 12'd2, 12'd1, 12'd2};
    load_timing();
    run_command(OP_WRITE, 8'h5A, LINE_RANDOM, 0);
    run_command(OP_RESET, 8'h00, LINE_DEVICE, 0);

    // short write slot with a one tick opening
    timing_set = '{12'd3, 12'd1, 12'd4, 12'd1, 12'd2, 12'd1, 12'd3, 12'd1};
    load_timing();
    run_command(OP_WRITE, 8'hC3, LINE_RANDOM, 0);
    run_command(OP_READ, 8'h00, LINE_RANDOM, 0);

    // random commands under random short timing
    random_start = sb.ticks;
    next_cfg = 0;
    holds = 0;
    while (sb.ticks < random_start + RANDOM_TICKS) begin
      n = sb.ticks - random_start;
      if (n >= next_cfg) begin
        foreach (timing_set[i])
          timing_set[i] = ($urandom_range(7) == 0) ? REG_WIDTH'($urandom_range(40))
                                                   : REG_WIDTH'($urandom_range(6));
        if ($urandom_range(3) == 0) timing_set[REG_BYTE_GAP] = '0;
        load_timing();
        next_cfg += CFG_EVERY;
      end
      if (n < RANDOM_TICKS / 3) begin
        tx_idle_pct = 28;
        rx_idle_pct = 52;
      end else if (n < 2 * RANDOM_TICKS / 3) begin
        tx_idle_pct = 52;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold while ticks keep coming
      if ((holds == 0 && n >= 100) || (holds == 1 && n >= 700)) begin
        hold_req = 1'b1;
        holds++;
      end
      r = $urandom_range(9);
      op = (r == 0) ? OP_NONE : (r <= 3) ? OP_RESET : (r <= 6) ? OP_WRITE : OP_READ;
      mode = (op == OP_RESET && $urandom_range(1) == 1) ? LINE_DEVICE : LINE_RANDOM;
      run_command(op, 8'($urandom_range(255)), mode, 10);
    end

    // wider timing values, one command of each kind
    timing_set = '{12'd100, 12'd37, 12'd64, 12'd9, 12'd24, 12'd50, 12'd5, 12'd11};
    load_timing();
    run_command(OP_RESET, 8'h00, LINE_DEVICE, 1);
    run_command(OP_WRITE, 8'h3C, LINE_RANDOM, 1);
    run_command(OP_READ, 8'h00, LINE_RANDOM, 1);

    quiesce();
    sb.errors += sb.expected_ticks.size();
    $display("covered %0d ticks: %0d resets (%0d with presence), %0d writes, %0d reads",
             sb.ticks, sb.cmd_count[OP_RESET], sb.presence_hits, sb.cmd_count[OP_WRITE],
             sb.cmd_count[OP_READ]);
    $display("%0d busy commands rejected over %0d timing settings, %0d mismatches",
             sb.rejects, timing_loads + 1, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS one_wire_bus_master");
    end else begin
      $display("FAIL one_wire_bus_master");
    end
    $finish;
  end

endmodule
